// ----- design/cbfd_pkg.sv -----
// cbfd_pkg: shared constants, types and the output rounding function
// for the cubic bezier forward difference block. no dependencies.
package cbfd_pkg;

    localparam int MAX_STEPS  = 64;
    localparam int EXTRA_FRAC = 24;
    localparam int DW         = 32;
    localparam int CW         = 7;
    localparam int MW         = 6;
    localparam int ACC_W      = 64;
    localparam int COEF_W     = 36;
    localparam int DIV_W      = 64;
    localparam int DIV_BITS   = 8;
    localparam int DIV_CYCLES = DIV_W / DIV_BITS;
    localparam int DIV_CNT_W  = 3;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PW    = 1;
    localparam int FIFO_CW    = 2;

    localparam logic [CW-1:0] STEPS_RESET = 7'd16;
    localparam logic [CW-1:0] STEPS_MAX   = 7'd64;

    typedef logic [ACC_W-1:0] acc_t;

    // one segment, ready to be stepped out by the back end
    typedef struct packed {
        acc_t [2:0]    pos;
        acc_t [2:0]    d1;
        acc_t [2:0]    d2;
        acc_t [2:0]    d3;
        logic [CW-1:0] count;
    } job_t;

    // round half up then saturate to 32 bits
    function automatic logic [DW-1:0] to_output(input acc_t acc);
        logic signed [ACC_W-1:0] v;
        logic signed [ACC_W-EXTRA_FRAC-1:0] r;
        logic [DW-1:0] res;
        v = $signed(acc + (acc_t'(1) << (EXTRA_FRAC - 1)));
        r = v[ACC_W-1:EXTRA_FRAC];
        if (r > $signed((ACC_W-EXTRA_FRAC)'(32'sh7fffffff))) begin
            res = 32'h7fffffff;
        end else if (r < -$signed((ACC_W-EXTRA_FRAC)'(33'sh080000000))) begin
            res = 32'h80000000;
        end else begin
            res = r[DW-1:0];
        end
        return res;
    endfunction

endpackage

// ----- design/cubic_bezier_forward_difference.sv -----
// Cubic Bezier forward differencing: each input transaction is one segment of
// four 3-D Q16.16 control points; the block emits steps_count points (0..64,
// larger values act as 64) on the output stream, the last one flagged by tlast.
// The front end uses three 8-bit-per-cycle dividers, one per axis, doing six
// chained divisions by m = count-1 (skipped when the count is 1); the back end
// then emits one point per cycle while the output is not stalled, taking each
// job from a two-entry queue that decouples the two ends. A count of 1 returns
// p0, a count of 0 emits nothing.
// Depends on cbfd_pkg, cbfd_front, cbfd_fifo, cbfd_back.
module cubic_bezier_forward_difference (
    input  logic         aclk,
    input  logic         aresetn,
    // p0_x, p0_y, p0_z, p1_x .. p3_z, 32 bits each from bit 0 up
    input  logic [383:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x, point_y, point_z, 32 bits each from bit 0 up
    output logic [95:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [cbfd_pkg::CW-1:0] steps_reg;
    logic                    job_valid, job_full, job_empty, job_pop;
    cbfd_pkg::job_t          front_job, queue_job;

    // register file
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-cbfd_pkg::CW){1'b0}}, steps_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= cbfd_pkg::STEPS_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            steps_reg <= pwdata[cbfd_pkg::CW-1:0];
        end
    end

    cbfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .steps_count (steps_reg),
        .job_valid   (job_valid),
        .job_full    (job_full),
        .job         (front_job)
    );

    cbfd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_valid),
        .push_job (front_job),
        .pop      (job_pop),
        .pop_job  (queue_job),
        .full     (job_full),
        .empty    (job_empty)
    );

    cbfd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_empty (job_empty),
        .job       (queue_job),
        .job_pop   (job_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- design/cbfd_div.sv -----
// cbfd_div: shift-subtract divider by a small divisor, eight quotient bits
// per cycle in which step is high. uses cbfd_pkg.
module cbfd_div (
    input  logic                        aclk,
    input  logic                        load,
    input  logic [cbfd_pkg::DIV_W-1:0]  load_value,
    input  logic                        step,
    input  logic [cbfd_pkg::MW-1:0]     divisor,
    output logic [cbfd_pkg::DIV_W-1:0]  quotient
);

    logic [cbfd_pkg::DIV_W-1:0] dv_reg, dv_next;
    logic [cbfd_pkg::MW-1:0]    rem_reg, rem_next;

    // eight restoring steps; quotient bits shift in from the bottom
    always_comb begin
        logic [cbfd_pkg::MW:0] t;
        dv_next  = dv_reg;
        rem_next = rem_reg;
        for (int i = 0; i < cbfd_pkg::DIV_BITS; i++) begin
            t       = {rem_next, dv_next[cbfd_pkg::DIV_W-1]};
            dv_next = dv_next << 1;
            if (t >= {1'b0, divisor}) begin
                t          = t - {1'b0, divisor};
                dv_next[0] = 1'b1;
            end
            rem_next = t[cbfd_pkg::MW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            dv_reg  <= load_value;
            rem_reg <= '0;
        end else if (step) begin
            dv_reg  <= dv_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = dv_reg;

endmodule

// ----- design/cbfd_front.sv -----
// cbfd_front: accepts a segment, forms the per-axis coefficients, scales
// them by 1/m, 1/m^2, 1/m^3 and builds the difference job. uses cbfd_pkg, cbfd_div.
module cbfd_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [383:0]               s_tdata,
    input  logic [cbfd_pkg::CW-1:0]    steps_count,
    output logic                       job_valid,
    input  logic                       job_full,
    output cbfd_pkg::job_t             job
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COEF = 3'd1;
    localparam logic [2:0] S_M3   = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_NEXT = 3'd5;
    localparam logic [2:0] S_DIFF = 3'd6;
    localparam logic [2:0] S_PUSH = 3'd7;

    localparam logic [1:0] Q_A = 2'd0;
    localparam logic [1:0] Q_B = 2'd1;
    localparam logic [1:0] Q_C = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] q_reg, q_next;
    logic [1:0] pass_reg, pass_next;
    logic [cbfd_pkg::DIV_CNT_W-1:0] bit_reg, bit_next;

    logic signed [cbfd_pkg::DW-1:0]     p_reg [4][3];
    logic signed [cbfd_pkg::COEF_W-1:0] coef_reg [3][3];
    cbfd_pkg::acc_t                     t_reg [3][3];
    logic [2:0]                         neg_reg;
    logic [cbfd_pkg::CW-1:0]            n_reg;
    logic [cbfd_pkg::MW-1:0]            m_reg;
    logic [2*cbfd_pkg::MW-1:0]          m2_reg;
    logic [3*cbfd_pkg::MW-1:0]          m3_reg;
    cbfd_pkg::job_t                     job_reg;

    logic                               div_load, div_step;
    logic [cbfd_pkg::DIV_W-1:0]         div_in  [3];
    logic [cbfd_pkg::DIV_W-1:0]         div_out [3];
    logic [3*cbfd_pkg::MW-1:0]          den;
    logic [cbfd_pkg::CW-1:0]            n_clamp;

    assign s_tready  = (state_reg == S_IDLE);
    assign job_valid = (state_reg == S_PUSH) && !job_full;
    assign job       = job_reg;
    assign n_clamp   = (steps_count > cbfd_pkg::STEPS_MAX) ? cbfd_pkg::STEPS_MAX : steps_count;

    // divisor of the current coefficient
    always_comb begin
        case (q_reg)
            Q_A:     den = m3_reg;
            Q_B:     den = {{cbfd_pkg::MW{1'b0}}, m2_reg};
            default: den = {{(2*cbfd_pkg::MW){1'b0}}, m_reg};
        endcase
    end

    // divider lanes, one per axis
    for (genvar ax = 0; ax < 3; ax++) begin : g_lane
        logic signed [cbfd_pkg::COEF_W-1:0] v;
        logic [cbfd_pkg::COEF_W-1:0]        mag;
        assign v   = coef_reg[q_reg][ax];
        assign mag = v[cbfd_pkg::COEF_W-1] ? cbfd_pkg::COEF_W'(-v) : cbfd_pkg::COEF_W'(v);
        assign div_in[ax] = (state_reg == S_LOAD)
            ? ({{(cbfd_pkg::DIV_W-cbfd_pkg::COEF_W-cbfd_pkg::EXTRA_FRAC){1'b0}},
                mag, {cbfd_pkg::EXTRA_FRAC{1'b0}}}
               + {{(cbfd_pkg::DIV_W-3*cbfd_pkg::MW){1'b0}}, den >> 1})
            : div_out[ax];
        cbfd_div u_div (
            .aclk       (aclk),
            .load       (div_load),
            .load_value (div_in[ax]),
            .step       (div_step),
            .divisor    (m_reg),
            .quotient   (div_out[ax])
        );
    end

    assign div_load = (state_reg == S_LOAD) || ((state_reg == S_NEXT) && (pass_reg > 2'd1));
    assign div_step = (state_reg == S_DIV);

    // sequencer
    always_comb begin
        state_next = state_reg;
        q_next     = q_reg;
        pass_next  = pass_reg;
        bit_next   = bit_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && (n_clamp != '0)) begin
                    state_next = S_COEF;
                end
            end
            S_COEF: begin
                state_next = (n_reg == cbfd_pkg::CW'(1)) ? S_DIFF : S_M3;
                q_next     = Q_A;
            end
            S_M3: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                state_next = S_DIV;
                bit_next   = '0;
                case (q_reg)
                    Q_A:     pass_next = 2'd3;
                    Q_B:     pass_next = 2'd2;
                    default: pass_next = 2'd1;
                endcase
            end
            S_DIV: begin
                bit_next = bit_reg + 1'b1;
                if (bit_reg == cbfd_pkg::DIV_CNT_W'(cbfd_pkg::DIV_CYCLES - 1)) begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                if (pass_reg > 2'd1) begin
                    pass_next  = pass_reg - 1'b1;
                    bit_next   = '0;
                    state_next = S_DIV;
                end else if (q_reg == Q_C) begin
                    state_next = S_DIFF;
                end else begin
                    q_next     = q_reg + 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_DIFF: begin
                state_next = S_PUSH;
            end
            S_PUSH: begin
                if (!job_full) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            q_reg     <= Q_A;
            pass_reg  <= '0;
            bit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            q_reg     <= q_next;
            pass_reg  <= pass_next;
            bit_reg   <= bit_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            for (int j = 0; j < 4; j++) begin
                for (int ax = 0; ax < 3; ax++) begin
                    p_reg[j][ax] <= s_tdata[(j*3+ax)*cbfd_pkg::DW +: cbfd_pkg::DW];
                end
            end
            n_reg <= n_clamp;
            m_reg <= cbfd_pkg::MW'(n_clamp - 1'b1);
        end
        if (state_reg == S_COEF) begin
            m2_reg <= {{cbfd_pkg::MW{1'b0}}, m_reg} * {{cbfd_pkg::MW{1'b0}}, m_reg};
            for (int ax = 0; ax < 3; ax++) begin
                coef_reg[0][ax] <= -cbfd_pkg::COEF_W'(p_reg[0][ax])
                                   + 3 * cbfd_pkg::COEF_W'(p_reg[1][ax])
                                   - 3 * cbfd_pkg::COEF_W'(p_reg[2][ax])
                                   + cbfd_pkg::COEF_W'(p_reg[3][ax]);
                coef_reg[1][ax] <= 3 * cbfd_pkg::COEF_W'(p_reg[0][ax])
                                   - 6 * cbfd_pkg::COEF_W'(p_reg[1][ax])
                                   + 3 * cbfd_pkg::COEF_W'(p_reg[2][ax]);
                coef_reg[2][ax] <= -3 * cbfd_pkg::COEF_W'(p_reg[0][ax])
                                   + 3 * cbfd_pkg::COEF_W'(p_reg[1][ax]);
            end
        end
        if (state_reg == S_M3) begin
            m3_reg <= {{cbfd_pkg::MW{1'b0}}, m2_reg}
                      * {{(2*cbfd_pkg::MW){1'b0}}, m_reg};
        end
        if (state_reg == S_LOAD) begin
            for (int ax = 0; ax < 3; ax++) begin
                neg_reg[ax] <= coef_reg[q_reg][ax][cbfd_pkg::COEF_W-1];
            end
        end
        // store the signed scaled coefficient after its last pass
        if ((state_reg == S_NEXT) && (pass_reg <= 2'd1)) begin
            for (int ax = 0; ax < 3; ax++) begin
                t_reg[q_reg][ax] <= neg_reg[ax] ? -div_out[ax] : div_out[ax];
            end
        end
        if (state_reg == S_DIFF) begin
            job_reg.count <= n_reg;
            for (int ax = 0; ax < 3; ax++) begin
                job_reg.pos[ax] <= {{(cbfd_pkg::ACC_W-cbfd_pkg::DW-cbfd_pkg::EXTRA_FRAC)
                                     {p_reg[0][ax][cbfd_pkg::DW-1]}},
                                    p_reg[0][ax], {cbfd_pkg::EXTRA_FRAC{1'b0}}};
                if (n_reg == cbfd_pkg::CW'(1)) begin
                    job_reg.d1[ax] <= '0;
                    job_reg.d2[ax] <= '0;
                    job_reg.d3[ax] <= '0;
                end else begin
                    job_reg.d1[ax] <= t_reg[0][ax] + t_reg[1][ax] + t_reg[2][ax];
                    job_reg.d2[ax] <= (t_reg[0][ax] << 2) + (t_reg[0][ax] << 1)
                                      + (t_reg[1][ax] << 1);
                    job_reg.d3[ax] <= (t_reg[0][ax] << 2) + (t_reg[0][ax] << 1);
                end
            end
        end
    end

endmodule

// ----- design/cbfd_fifo.sv -----
// cbfd_fifo: two-entry job queue between the front and back ends.
// uses cbfd_pkg.
module cbfd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cbfd_pkg::job_t push_job,
    input  logic           pop,
    output cbfd_pkg::job_t pop_job,
    output logic           full,
    output logic           empty
);

    cbfd_pkg::job_t                  mem [cbfd_pkg::FIFO_DEPTH];
    logic [cbfd_pkg::FIFO_PW-1:0]    wr_reg, rd_reg;
    logic [cbfd_pkg::FIFO_CW-1:0]    cnt_reg, cnt_next;

    assign full    = (cnt_reg == cbfd_pkg::FIFO_CW'(cbfd_pkg::FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_job = mem[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_job;
        end
    end

endmodule

// ----- design/cbfd_back.sv -----
// cbfd_back: steps a job through its points, one per cycle while the output
// is not stalled, into the output register. uses cbfd_pkg.
module cbfd_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           job_empty,
    input  cbfd_pkg::job_t job,
    output logic           job_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [95:0]    m_tdata,
    output logic           m_tlast
);

    logic                    active_reg, active_next;
    logic [cbfd_pkg::CW-1:0] k_reg, k_next;
    cbfd_pkg::job_t          work_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [95:0]             m_tdata_reg;
    logic                    m_tlast_reg;
    logic                    emit, is_last;

    assign job_pop = !active_reg && !job_empty;
    assign emit    = active_reg && (!m_tvalid_reg || m_tready);
    assign is_last = (k_reg == work_reg.count - 1'b1);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        active_next   = active_reg;
        k_next        = k_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (job_pop) begin
            active_next = 1'b1;
            k_next      = '0;
        end else if (emit) begin
            m_tvalid_next = 1'b1;
            k_next        = k_reg + 1'b1;
            if (is_last) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            active_reg   <= active_next;
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // difference chain and output rounding
    always_ff @(posedge aclk) begin
        if (job_pop) begin
            work_reg <= job;
        end else if (emit) begin
            for (int ax = 0; ax < 3; ax++) begin
                m_tdata_reg[ax*cbfd_pkg::DW +: cbfd_pkg::DW]
                    <= cbfd_pkg::to_output(work_reg.pos[ax]);
                work_reg.pos[ax] <= work_reg.pos[ax] + work_reg.d1[ax];
                work_reg.d1[ax]  <= work_reg.d1[ax] + work_reg.d2[ax];
                work_reg.d2[ax]  <= work_reg.d2[ax] + work_reg.d3[ax];
            end
            m_tlast_reg <= is_last;
        end
    end

endmodule

// ----- design/cbfd_checker.sv -----
// cbfd_checker: port-level checks for the forward difference block, bound
// to the top level. no package dependencies.
module cbfd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic [95:0]  m_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic         m_tlast,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [2:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata
);

    // a stalled output transaction stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // reset empties the output register
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a count write reads back
    a_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && !paddr[2]) ##1 !paddr[2]
        |-> prdata[6:0] == $past(pwdata[6:0]))
        else $error("steps_count readback mismatch");

endmodule

bind cubic_bezier_forward_difference cbfd_checker u_cbfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
